[design/assert_macros.svh]
// assertion macros included by the point evaluator design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge of clk, skipped while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/cbez_pkg.sv]
// shared constants and types for the cubic bezier evaluator
`timescale 1ns / 1ps

package cbez_pkg;

  // coordinate and curve parameter formats
  localparam int COORD_W  = 16;
  localparam int FRAC_W   = 16;
  localparam int T_W      = FRAC_W + 1;
  localparam int NUM_AXES = 3;
  localparam int PACK_W   = NUM_AXES * COORD_W;

  // curve shape
  localparam int DEGREE   = 3;
  localparam int NUM_CTRL = DEGREE + 1;
  localparam int CFG_IDX_W = $clog2(NUM_CTRL);

  // lerp cell arithmetic
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + T_W + 1;
  localparam int SHR_W  = PROD_W - FRAC_W;

  // pipeline depth: parameter register plus two stages per level
  localparam int CELL_LAT = 2;
  localparam int PIPE_LAT = 1 + DEGREE * CELL_LAT;

  localparam logic [T_W-1:0]    T_ONE  = T_W'(1) << FRAC_W;
  localparam logic [PROD_W-1:0] T_HALF = PROD_W'(1) << (FRAC_W - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CP0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CP1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CP2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CP3 = CFG_IDX_W'(3);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [T_W-1:0]            param_t;
  typedef logic [PACK_W-1:0]         packed_pt_t;

endpackage

[design/cbez_lerp_cell.sv]
// one fixed point lerp cell of the de casteljau chain, two stages deep
`timescale 1ns / 1ps

module cbez_lerp_cell import cbez_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  coord_t a,
  input  coord_t b,
  input  param_t t_in,
  output coord_t q,
  output param_t t_out
);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  coord_t                   a_d;
  param_t                   t_d;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SHR_W-1:0]  shr;
  logic signed [SHR_W-1:0]  sum;

  // a*(1-t) + b*t folded into a + (b-a)*t
  assign diff = DIFF_W'(b) - DIFF_W'(a);

  // stage one: product of the difference and t
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(diff) * $signed({1'b0, t_in});
      a_d  <= a;
      t_d  <= t_in;
    end
  end

  // round, floor shift, add back the base point
  assign rnd = prod + $signed(T_HALF);
  assign shr = rnd[PROD_W-1:FRAC_W];
  assign sum = shr + SHR_W'(a_d);

  // stage two: result and parameter to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      q     <= sum[COORD_W-1:0];
      t_out <= t_d;
    end
  end

endmodule

[design/cubic_bezier_point_evaluator.sv]
// cubic bezier point evaluator, a chain of lerp cells one level per pair of stages
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//   in      | in_valid in_ready curve_param             | in
//   out     | out_valid out_ready point_x point_y point_z | out
//
// one point per clock while the chain does not hold; the stages are the parameter register, then three
// levels of lerp cells with a multiply stage and a round/add stage each
// the whole chain holds while a finished point waits and out_ready is low
// synchronous reset clears the valid bits and sets the control points to zero
// cfg_ready is always high; writes take effect in the next cycle
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cubic_bezier_point_evaluator import cbez_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  packed_pt_t           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  param_t               curve_param,
  output logic                 out_valid,
  input  logic                 out_ready,
  output coord_t               point_x,
  output coord_t               point_y,
  output coord_t               point_z
);

  packed_pt_t            ctrl [NUM_CTRL];
  logic [PIPE_LAT-1:0]   vld;
  logic                  advance;
  param_t                t_sat;
  param_t                t_lvl [DEGREE+1];
  coord_t                pts [NUM_AXES][DEGREE+1][NUM_CTRL];

  // control point registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CTRL; i++) begin
        ctrl[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CP0: ctrl[0] <= cfg_data;
        REG_CP1: ctrl[1] <= cfg_data;
        REG_CP2: ctrl[2] <= cfg_data;
        REG_CP3: ctrl[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control: the chain moves unless a finished point is stuck
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign out_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  // parameter above one saturates to one
  assign t_sat = (curve_param > T_ONE) ? T_ONE : curve_param;

  always_ff @(posedge clk) begin
    if (advance) begin
      t_lvl[0] <= t_sat;
    end
  end

  // level zero is the control points themselves
  genvar ax, lv, pi;
  generate
    for (ax = 0; ax < NUM_AXES; ax++) begin : g_axis
      for (pi = 0; pi < NUM_CTRL; pi++) begin : g_ctrl
        assign pts[ax][0][pi] = ctrl[pi][ax*COORD_W +: COORD_W];
      end
      for (lv = 1; lv <= DEGREE; lv++) begin : g_lvl
        for (pi = 0; pi + lv <= DEGREE; pi++) begin : g_cell
          if (ax == 0 && pi == 0) begin : g_tap
            cbez_lerp_cell u_cell (
              .clk   (clk),
              .en    (advance),
              .a     (pts[ax][lv-1][pi]),
              .b     (pts[ax][lv-1][pi+1]),
              .t_in  (t_lvl[lv-1]),
              .q     (pts[ax][lv][pi]),
              .t_out (t_lvl[lv])
            );
          end else begin : g_plain
            cbez_lerp_cell u_cell (
              .clk   (clk),
              .en    (advance),
              .a     (pts[ax][lv-1][pi]),
              .b     (pts[ax][lv-1][pi+1]),
              .t_in  (t_lvl[lv-1]),
              .q     (pts[ax][lv][pi]),
              .t_out ()
            );
          end
        end
      end
    end
  endgenerate

  // the last cell of each axis holds the result
  assign point_x = pts[0][DEGREE][0];
  assign point_y = pts[1][DEGREE][0];
  assign point_z = pts[2][DEGREE][0];

  // checks
  `ASSERT_CLK(a_accept_enters, in_valid && in_ready |=> vld[0], "accepted item lost at entry")
  `ASSERT_CLK(a_stall_holds, !advance |=> $stable(vld), "chain moved during a stall")
  `ASSERT_CLK(a_param_sat, vld[0] |-> t_lvl[0] <= T_ONE, "parameter above one reached cells")

endmodule

[tb/sv/tb_cubic_bezier_point_evaluator.sv]
// self-checking testbench for the cubic bezier point evaluator
`timescale 1ns / 1ps

module tb_cubic_bezier_point_evaluator;
  import cbez_pkg::*;

  // no-transfer cycles before the run is declared hung
  localparam int unsigned STALL_LIMIT = 5000;
  localparam longint TQ_ONE  = longint'(1) << FRAC_W;
  localparam longint TQ_HALF = longint'(1) << (FRAC_W - 1);

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } bez_point_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  packed_pt_t           cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  param_t               curve_param;
  logic                 out_valid;
  logic                 out_ready;
  coord_t               point_x;
  coord_t               point_y;
  coord_t               point_z;

  // shadow copy of the control point registers
  packed_pt_t  ctrl_pts [NUM_CTRL];
  bez_point_t  pending_points [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          idling_on;

  cubic_bezier_point_evaluator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .curve_param (curve_param),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one interpolation step, rounded, floor shift
  function automatic longint lerp_round(longint a, longint b, longint t);
    return (a * (TQ_ONE - t) + b * t + TQ_HALF) >>> FRAC_W;
  endfunction

  // point on the curve for parameter t, three levels of interpolation per axis
  function automatic bez_point_t bezier_point(param_t t_raw);
    longint     t;
    longint     c [NUM_CTRL];
    coord_t     res [NUM_AXES];
    bez_point_t p;
    // parameter above one clamps to the end point
    t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int i = 0; i < NUM_CTRL; i++) begin
        c[i] = longint'(coord_t'(ctrl_pts[i][a*COORD_W +: COORD_W]));
      end
      for (int k = 1; k <= DEGREE; k++) begin
        for (int i = 0; i + k <= DEGREE; i++) begin
          c[i] = lerp_round(c[i], c[i+1], t);
        end
      end
      res[a] = coord_t'(c[0]);
    end
    p.x = res[0];
    p.y = res[1];
    p.z = res[2];
    return p;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // send one curve parameter; returns at the edge where it transfers
  task automatic send_param(param_t t);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    curve_param = t;
    do @(posedge clk); while (!in_ready);
    pending_points.push_back(bezier_point(t));
  endtask

  // register write, only while the pipeline is empty
  task automatic write_cp(logic [CFG_IDX_W-1:0] idx, packed_pt_t val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    ctrl_pts[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(packed_pt_t p0, packed_pt_t p1, packed_pt_t p2, packed_pt_t p3);
    write_cp(REG_CP0, p0);
    write_cp(REG_CP1, p1);
    write_cp(REG_CP2, p2);
    write_cp(REG_CP3, p3);
  endtask

  // drop valid and wait until every point has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  function automatic packed_pt_t rand_cp();
    packed_pt_t  p;
    int unsigned r;
    for (int a = 0; a < NUM_AXES; a++) begin
      r = $urandom_range(0, 9);
      if (r == 0) p[a*COORD_W +: COORD_W] = coord_t'(16'h7fff);
      else if (r == 1) p[a*COORD_W +: COORD_W] = coord_t'(16'h8000);
      else p[a*COORD_W +: COORD_W] = coord_t'($urandom);
    end
    return p;
  endfunction

  function automatic param_t rand_param();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return param_t'($urandom_range(0, 65536));
    if (r < 85) return param_t'($urandom_range(65537, 131071));
    case ($urandom_range(0, 4))
      0: return param_t'(0);
      1: return param_t'(1);
      2: return param_t'(32768);
      3: return param_t'(65535);
      default: return T_ONE;
    endcase
  endfunction

  // output side backpressure
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      int unsigned n;
      n = idle_len();
      if (n != 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // result check against the oldest expected point
  always @(posedge clk) begin
    bez_point_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("point transfers pending", 1, 0);
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) report_mismatch("point_x", point_x, want.x);
        if (point_y !== want.y) report_mismatch("point_y", point_y, want.y);
        if (point_z !== want.z) report_mismatch("point_z", point_z, want.z);
      end
    end
  end

  // hang detection
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("tb_cubic_bezier_point_evaluator NOT OK");
        $finish;
      end
    end
  end

  // control points are zero after reset, so every point is the origin
  task automatic test_reset_values();
    send_param(param_t'(0));
    send_param(param_t'(32768));
    send_param(T_ONE);
    drain();
  endtask

  // extreme coordinates, parameter edges and clamping above one
  task automatic test_extremes();
    write_all(48'h8000_7fff_8000, 48'h7fff_8000_7fff, 48'haaaa_5555_ffff, 48'h5555_aaaa_0001);
    send_param(param_t'(0));
    send_param(param_t'(1));
    send_param(param_t'(2));
    send_param(param_t'(16384));
    send_param(param_t'(32767));
    send_param(param_t'(32768));
    send_param(param_t'(32769));
    send_param(param_t'(49152));
    send_param(param_t'(65534));
    send_param(param_t'(65535));
    send_param(T_ONE);
    send_param(param_t'(65537));
    send_param(param_t'(98304));
    send_param(param_t'(131071));
    drain();
    write_all(48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff);
    send_param(param_t'(0));
    send_param(param_t'(21845));
    drain();
    write_all(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
    send_param(param_t'(43690));
    send_param(param_t'(131071));
    drain();
  endtask

  // random curves, each phase with a fresh set of control points
  task automatic test_random_curves();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_all(48'h7fff_8000_7fff, 48'h8000_7fff_8000, 48'h7fff_8000_7fff,
                     48'h8000_7fff_8000);
        1: write_all(48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h8000_8000_8000,
                     48'h7fff_7fff_7fff);
        default: write_all(rand_cp(), rand_cp(), rand_cp(), rand_cp());
      endcase
      // one phase runs with no idling on either side
      idling_on = (ph != 5);
      for (int n = 0; n < 150; n++) send_param(rand_param());
      drain();
    end
    idling_on = 1'b1;
  endtask

  // full rate burst with the ready side held high
  task automatic test_full_rate();
    idling_on = 1'b0;
    write_all(rand_cp(), rand_cp(), rand_cp(), rand_cp());
    for (int n = 0; n < 50; n++) send_param(rand_param());
    drain();
    idling_on = 1'b1;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = REG_CP0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    curve_param = '0;
    idling_on   = 1'b1;
    mismatches  = 0;
    idle_cycles = 0;
    for (int i = 0; i < NUM_CTRL; i++) ctrl_pts[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_extremes();
    test_random_curves();
    test_full_rate();

    drain();
    if (mismatches == 0) begin
      $display("tb_cubic_bezier_point_evaluator OK");
    end else begin
      $display("tb_cubic_bezier_point_evaluator NOT OK");
    end
    $finish;
  end

endmodule
